@@ rtl/core/u8u16_pkg.sv @@
// Package: shared types and constants of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package u8u16_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  localparam int unsigned CpW = 21;

  localparam logic [15:0]    HighSurr  = 16'hD800;
  localparam logic [15:0]    LowSurr   = 16'hDC00;
  localparam logic [CpW-1:0] PlaneBase = 21'h010000;
  localparam logic [CpW-1:0] CpLimit   = 21'h110000;
  localparam logic [7:0]     ContMask  = 8'hC0;
  localparam logic [7:0]     ContTag   = 8'h80;

  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] unit0;
    status_e     st0;
    logic        last0;
    logic [15:0] unit1;
  } step_res_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic [1:0]     rem;
  } dec_state_t;

endpackage

@@ rtl/core/u8u16_step.sv @@
// Step logic: decodes one byte against the gathered state into results and next state.
`timescale 1ns / 1ps

module u8u16_step (
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  u8u16_pkg::dec_state_t state_i,
  output u8u16_pkg::dec_state_t state_o,
  output u8u16_pkg::step_res_t  res_o
);

  logic                      err;
  u8u16_pkg::status_e        err_st;
  logic                      fin;
  logic [u8u16_pkg::CpW-1:0] c;
  logic [u8u16_pkg::CpW-1:0] v;
  logic                      loaded;
  logic [u8u16_pkg::CpW-1:0] cp_n;
  logic [1:0]                rem_n;

  always_comb begin
    err    = 1'b0;
    err_st = u8u16_pkg::ST_OK;
    fin    = 1'b0;
    c      = '0;
    loaded = 1'b0;
    cp_n   = state_i.cp;
    rem_n  = state_i.rem;
    if (state_i.rem == 2'd0) begin
      if (byte_i inside {[8'h00:8'h7F]}) begin
        fin = 1'b1;
        c   = {13'd0, byte_i};
      end else if (byte_i inside {[8'hC0:8'hDF]}) begin
        cp_n   = {16'd0, byte_i[4:0]};
        rem_n  = 2'd1;
        loaded = 1'b1;
      end else if (byte_i inside {[8'hE0:8'hEF]}) begin
        cp_n   = {17'd0, byte_i[3:0]};
        rem_n  = 2'd2;
        loaded = 1'b1;
      end else if (byte_i inside {[8'hF0:8'hF7]}) begin
        cp_n   = {18'd0, byte_i[2:0]};
        rem_n  = 2'd3;
        loaded = 1'b1;
      end else begin
        err    = 1'b1;
        err_st = u8u16_pkg::ST_BAD_LEAD;
      end
      if (loaded && last_i) begin
        err    = 1'b1;
        err_st = u8u16_pkg::ST_TRUNCATED;
      end
    end else if ((byte_i & u8u16_pkg::ContMask) != u8u16_pkg::ContTag) begin
      err    = 1'b1;
      err_st = u8u16_pkg::ST_BAD_CONT;
    end else begin
      cp_n  = {state_i.cp[u8u16_pkg::CpW-7:0], byte_i[5:0]};
      rem_n = state_i.rem - 2'd1;
      if (rem_n == 2'd0) begin
        fin = 1'b1;
        c   = cp_n;
      end else if (last_i) begin
        err    = 1'b1;
        err_st = u8u16_pkg::ST_TRUNCATED;
      end
    end

    if (fin && (c >= u8u16_pkg::CpLimit)) begin
      fin    = 1'b0;
      err    = 1'b1;
      err_st = u8u16_pkg::ST_TOO_LARGE;
    end

    v = c - u8u16_pkg::PlaneBase;

    res_o.count = 2'd0;
    res_o.unit0 = '0;
    res_o.st0   = u8u16_pkg::ST_OK;
    res_o.last0 = 1'b1;
    res_o.unit1 = u8u16_pkg::LowSurr | {6'd0, v[9:0]};
    if (err) begin
      res_o.count = 2'd1;
      res_o.st0   = err_st;
    end else if (fin) begin
      if (c < u8u16_pkg::PlaneBase) begin
        res_o.count = 2'd1;
        res_o.unit0 = c[15:0];
      end else begin
        res_o.count = 2'd2;
        res_o.unit0 = u8u16_pkg::HighSurr | {6'd0, v[19:10]};
        res_o.last0 = 1'b0;
      end
    end

    if (err || fin) begin
      state_o.cp  = '0;
      state_o.rem = 2'd0;
    end else begin
      state_o.cp  = cp_n;
      state_o.rem = rem_n;
    end
  end

endmodule

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// Top level: streaming UTF-8 byte to UTF-16 code unit decoder.
//
// Slave channel s_axis takes one UTF-8 byte per request in tdata, with tlast
// marking the final byte of the stream. Master channel m_axis gives one
// UTF-16 code unit per request in tdata, the status code in tuser, and tlast
// on the final result caused by a byte.
// A byte is held in the input register and is decoded into the result
// register, from which its first result is offered; while the result
// register is stalled, the byte waits in the input register.
// Throughput is one byte per cycle while results are taken; a pair of
// surrogates holds the result register, and so the input register, until
// both are taken. Lead and continuation bytes that finish nothing yield
// no result. Errors yield one result with code unit zero and return to
// expecting a lead. When the receiver stalls, the result register holds
// and the input register still takes one more byte before tready drops.
// Reset clears both registers' valid flags and the gathered code point state.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [15:0] code_unit
  output logic [2:0]  m_axis_tuser_o,  // [2:0] status
  output logic        m_axis_tlast_o   // last_of_run
);

  logic                  in_vld_q;
  logic [7:0]            in_byte_q;
  logic                  in_last_q;
  u8u16_pkg::dec_state_t st_q, st_d;
  u8u16_pkg::step_res_t  res;
  logic                  out_vld_q;
  logic                  pend_q;
  logic [15:0]           out_unit_q;
  u8u16_pkg::status_e    out_st_q;
  logic                  out_last_q;
  logic [15:0]           sec_unit_q;
  logic                  out_fire;
  logic                  out_free;
  logic                  advance;
  logic                  in_fire;

  assign out_fire        = out_vld_q && m_axis_tready_i;
  assign out_free        = !out_vld_q || (m_axis_tready_i && !pend_q);
  assign advance         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  u8u16_step u_step (
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_i (st_q),
    .state_o (st_d),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.cp  <= '0;
      st_q.rem <= 2'd0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else if (advance) begin
      out_vld_q <= (res.count != 2'd0);
      pend_q    <= (res.count == 2'd2);
    end else if (out_fire) begin
      out_vld_q <= pend_q;
      pend_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_unit_q <= res.unit0;
      out_st_q   <= res.st0;
      out_last_q <= res.last0;
      sec_unit_q <= res.unit1;
    end else if (out_fire && pend_q) begin
      out_unit_q <= sec_unit_q;
      out_st_q   <= u8u16_pkg::ST_OK;
      out_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_unit_q;
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;

  a_pend_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_vld_q)
    else $error("second unit pending without a first result");

  a_pend_is_high_surr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (!m_axis_tlast_o && m_axis_tuser_o == u8u16_pkg::ST_OK
                && m_axis_tdata_o[15:10] == u8u16_pkg::HighSurr[15:10]))
    else $error("first unit of a pair is not a high surrogate");

  a_err_zero_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && m_axis_tuser_o != u8u16_pkg::ST_OK)
      |-> (m_axis_tdata_o == 16'd0 && m_axis_tlast_o))
    else $error("error result carries a code unit");

  a_pair_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && pend_q) |=> (out_vld_q && m_axis_tlast_o
                              && m_axis_tdata_o[15:10] == u8u16_pkg::LowSurr[15:10]))
    else $error("low surrogate did not follow high surrogate");

endmodule
